// ===== rtl/core/metropolis_lattice_spin_flip_top_macros.svh =====
// Assertion macros shared by the lattice spin-flip block.
`ifndef METROPOLIS_LATTICE_SPIN_FLIP_TOP_MACROS_SVH
`define METROPOLIS_LATTICE_SPIN_FLIP_TOP_MACROS_SVH

`ifndef SYNTHESIS
// General property, checked outside reset.
`define MLSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// A control flag is low in the cycle after any reset edge.
`define MLSF_ASSERT_RESET(lbl, clk, rstn, sig, msg) \
    lbl: assert property (@(posedge clk) !(rstn) |=> !(sig)) else $error(msg);
`else
`define MLSF_ASSERT(lbl, clk, rstn, prop, msg)
`define MLSF_ASSERT_RESET(lbl, clk, rstn, sig, msg)
`endif

`endif

// ===== rtl/core/mlsf_pkg.sv =====
`default_nettype none

package mlsf_pkg;

    // Lattice geometry: a square torus whose side is a power of two.
    localparam int unsigned COORD_W = 6;
    localparam int unsigned SIDE    = 1 << COORD_W;

    // Field widths.
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned DRAW_W   = 10;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned THR_W    = 10;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned DE_W     = 7;
    localparam int unsigned SLOTS    = 1 << LEVEL_W;

    // Neighborhood scan: five rows around the center, indexed 0..4.
    localparam int unsigned SCAN_ROWS = 5;
    localparam int unsigned K_W       = 3;
    localparam logic [K_W-1:0] ROW_CENTER = K_W'(2);

    // Item kinds.
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_THRESH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_STEP   = 2'd3;

    // Neighborhood modes; any other code acts as the eight-cell mode.
    localparam logic [MODE_W-1:0] MODE_ORTHO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RING2 = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic           capture;
        logic           thr_write;
        logic           rd_en;
        logic [K_W-1:0] rd_k;
        logic           acc_clear;
        logic           row_use;
        logic           commit;
        logic           present;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlsf_ram.sv =====
`default_nettype none

module mlsf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mlsf_datapath.sv =====
`default_nettype none

module mlsf_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mlsf_pkg::MODE_W-1:0]         cfg_wr_data,
    input  wire logic [mlsf_pkg::ACTION_W-1:0]       s_action,
    input  wire logic [mlsf_pkg::COORD_W-1:0]        s_column,
    input  wire logic [mlsf_pkg::COORD_W-1:0]        s_row,
    input  wire logic                                s_spin_in,
    input  wire logic [mlsf_pkg::DRAW_W-1:0]         s_draw,
    input  wire logic [mlsf_pkg::LEVEL_W-1:0]        s_level,
    input  wire logic [mlsf_pkg::THR_W-1:0]          s_threshold_value,
    input  wire mlsf_pkg::cmd_t                      cmd,
    output logic                                     m_spin_out,
    output logic                                     m_accepted,
    output logic signed [mlsf_pkg::DE_W-1:0]         m_energy_change
);

    logic [mlsf_pkg::MODE_W-1:0]   mode_reg;
    logic [mlsf_pkg::ACTION_W-1:0] act_reg;
    logic [mlsf_pkg::COORD_W-1:0]  col_reg;
    logic [mlsf_pkg::COORD_W-1:0]  row_reg;
    logic                          spin_in_reg;
    logic [mlsf_pkg::DRAW_W-1:0]   draw_reg;
    logic [mlsf_pkg::THR_W-1:0]    thr_table_reg [mlsf_pkg::SLOTS];

    logic                          acc_en_reg;
    logic [mlsf_pkg::K_W-1:0]      acc_k_reg;
    logic signed [4:0]             near_sum_reg;
    logic signed [5:0]             far_sum_reg;
    logic [mlsf_pkg::SIDE-1:0]     center_row_reg;

    logic                          res_spin_reg;
    logic                          res_acc_reg;
    logic signed [mlsf_pkg::DE_W-1:0] res_de_reg;

    logic                          ram_we;
    logic [mlsf_pkg::COORD_W-1:0]  ram_raddr;
    logic [mlsf_pkg::SIDE-1:0]     ram_wdata;
    logic [mlsf_pkg::SIDE-1:0]     ram_rdata;
    logic [mlsf_pkg::SIDE-1:0]     load_row;
    logic [mlsf_pkg::SIDE-1:0]     flip_row;

    logic signed [3:0]             row_near;
    logic signed [3:0]             row_far;

    logic                          center_bit;
    logic signed [mlsf_pkg::DE_W-1:0] de_raw;
    logic signed [mlsf_pkg::DE_W-1:0] de_val;
    logic                          de_pos;
    logic [mlsf_pkg::LEVEL_W-1:0]  slot;
    logic                          accept_flip;
    logic                          is_load;

    // Row-wide lattice memory: one word per lattice row.
    mlsf_ram #(
        .WIDTH (mlsf_pkg::SIDE),
        .DEPTH (mlsf_pkg::SIDE)
    ) u_lattice (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Row address wraps around the torus through modular arithmetic.
    assign ram_raddr = row_reg + mlsf_pkg::COORD_W'(cmd.rd_k) - mlsf_pkg::COORD_W'(2);

    // Contribution of the row that just came out of memory.
    always_comb begin : row_sum
        int dr;
        int dc;
        int ar;
        int ac;
        int reach;
        int n;
        int near_acc;
        int far_acc;
        logic use_cell;
        logic [mlsf_pkg::COORD_W-1:0] cidx;
        near_acc = 0;
        far_acc  = 0;
        dr = int'(acc_k_reg) - 2;
        ar = (dr < 0) ? -dr : dr;
        for (int kc = 0; kc < 5; kc++) begin
            dc    = kc - 2;
            ac    = (dc < 0) ? -dc : dc;
            reach = (ar > ac) ? ar : ac;
            if (mode_reg == mlsf_pkg::MODE_ORTHO) begin
                use_cell = (ar + ac == 1);
            end else if (mode_reg == mlsf_pkg::MODE_RING2) begin
                use_cell = 1'b1;
            end else begin
                use_cell = (reach == 1);
            end
            cidx = col_reg + mlsf_pkg::COORD_W'(kc) - mlsf_pkg::COORD_W'(2);
            n = ram_rdata[cidx] ? 1 : -1;
            if (use_cell && reach == 1) begin
                near_acc = near_acc + n;
            end else if (use_cell && reach == 2) begin
                far_acc = far_acc + n;
            end
        end
        row_near = 4'(near_acc);
        row_far  = 4'(far_acc);
    end

    // Energy change of the trial flip and the acceptance test.
    assign center_bit = center_row_reg[col_reg];
    assign de_raw     = (mlsf_pkg::DE_W'(near_sum_reg) <<< 1) - mlsf_pkg::DE_W'(far_sum_reg);
    assign de_val     = center_bit ? de_raw : -de_raw;
    assign de_pos     = !de_val[mlsf_pkg::DE_W-1] && (de_val != '0);
    assign slot       = mlsf_pkg::LEVEL_W'(de_val[5:1] - 5'd1);
    assign accept_flip = !de_pos || (draw_reg < thr_table_reg[slot]);
    assign is_load    = (act_reg == mlsf_pkg::ACT_LOAD);

    // Write-back rows for a spin load and for a committed step.
    always_comb begin
        load_row = ram_rdata;
        load_row[col_reg] = spin_in_reg;
        flip_row = center_row_reg;
        flip_row[col_reg] = center_bit ^ accept_flip;
    end

    assign ram_we    = (cmd.row_use && is_load) || cmd.commit;
    assign ram_wdata = cmd.commit ? flip_row : load_row;

    // Control state: mode register and the accumulate strobe.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= mlsf_pkg::MODE_EIGHT;
            acc_en_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            acc_en_reg <= cmd.rd_en;
        end
    end

    // Item fields, threshold table, sums and results.
    always_ff @(posedge aclk) begin
        acc_k_reg <= cmd.rd_k;
        if (cmd.capture) begin
            act_reg     <= s_action;
            col_reg     <= s_column;
            row_reg     <= s_row;
            spin_in_reg <= s_spin_in;
            draw_reg    <= s_draw;
        end
        if (cmd.thr_write) begin
            thr_table_reg[s_level] <= s_threshold_value;
        end
        if (cmd.acc_clear) begin
            near_sum_reg <= '0;
            far_sum_reg  <= '0;
        end else if (acc_en_reg) begin
            near_sum_reg <= near_sum_reg + 5'(row_near);
            far_sum_reg  <= far_sum_reg + 6'(row_far);
            if (acc_k_reg == mlsf_pkg::ROW_CENTER) begin
                center_row_reg <= ram_rdata;
            end
        end
        if (cmd.thr_write) begin
            res_spin_reg <= 1'b0;
            res_acc_reg  <= 1'b0;
            res_de_reg   <= '0;
        end else if (cmd.row_use) begin
            res_spin_reg <= is_load ? spin_in_reg : ram_rdata[col_reg];
            res_acc_reg  <= 1'b0;
            res_de_reg   <= '0;
        end else if (cmd.commit) begin
            res_spin_reg <= center_bit ^ accept_flip;
            res_acc_reg  <= accept_flip;
            res_de_reg   <= de_val;
        end
        if (cmd.present) begin
            m_spin_out      <= res_spin_reg;
            m_accepted      <= res_acc_reg;
            m_energy_change <= res_de_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mlsf_ctrl.sv =====
`default_nettype none

`include "metropolis_lattice_spin_flip_top_macros.svh"

module mlsf_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mlsf_pkg::ACTION_W-1:0] s_action,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output mlsf_pkg::cmd_t                     cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ROW_RD  = 3'd1;
    localparam logic [2:0] S_ROW_USE = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_EVAL    = 3'd4;
    localparam logic [2:0] S_DECIDE  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [mlsf_pkg::K_W-1:0] cnt_reg;
    logic [mlsf_pkg::K_W-1:0] cnt_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Sequencer for one item at a time.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (s_action)
                        mlsf_pkg::ACT_LOAD, mlsf_pkg::ACT_READ: begin
                            state_next = S_ROW_RD;
                        end
                        mlsf_pkg::ACT_THRESH: begin
                            cmd.thr_write = 1'b1;
                            state_next    = S_DONE;
                        end
                        mlsf_pkg::ACT_STEP: begin
                            cmd.acc_clear = 1'b1;
                            cnt_next      = '0;
                            state_next    = S_SCAN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ROW_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = mlsf_pkg::ROW_CENTER;
                state_next = S_ROW_USE;
            end
            S_ROW_USE: begin
                cmd.row_use = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                cmd.rd_k  = cnt_reg;
                if (cnt_reg == mlsf_pkg::K_W'(mlsf_pkg::SCAN_ROWS - 1)) begin
                    state_next = S_EVAL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EVAL: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.present  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, scan counter and result-valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `MLSF_ASSERT_RESET(a_mvalid_rst, aclk, aresetn, m_valid_reg, "result valid after reset")
    `MLSF_ASSERT(a_busy_after_xfer, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready right after a transfer")
    `MLSF_ASSERT(a_scan_bound, aclk, aresetn, (state_reg == S_SCAN) |-> (cnt_reg < mlsf_pkg::K_W'(mlsf_pkg::SCAN_ROWS)), "scan counter out of range")
    `MLSF_ASSERT(a_present_from_done, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == S_DONE), "result raised outside the done state")
    `MLSF_ASSERT(a_done_holds, aclk, aresetn, (state_reg == S_DONE && m_valid_reg && !m_ready) |=> (state_reg == S_DONE), "pending result overwritten")

endmodule

`default_nettype wire

// ===== rtl/core/metropolis_lattice_spin_flip_top.sv =====
// From input transfer to result valid: a threshold write goes straight to the present
// step; a spin load or read does one row read and one row use; a Metropolis step does
// five row reads of the row-wide lattice memory, one accumulate, one decide/write-back
// and one present. A new item is taken only once the last result is presented.
// Reset (aresetn low, synchronous) clears control and sets the neighborhood mode to 1;
// lattice and threshold contents are undefined until written.
`default_nettype none

module metropolis_lattice_spin_flip_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mlsf_pkg::MODE_W-1:0]         cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [mlsf_pkg::ACTION_W-1:0]       s_action,
    input  wire logic [mlsf_pkg::COORD_W-1:0]        s_column,
    input  wire logic [mlsf_pkg::COORD_W-1:0]        s_row,
    input  wire logic                                s_spin_in,
    input  wire logic [mlsf_pkg::DRAW_W-1:0]         s_draw,
    input  wire logic [mlsf_pkg::LEVEL_W-1:0]        s_level,
    input  wire logic [mlsf_pkg::THR_W-1:0]          s_threshold_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_spin_out,
    output logic                                     m_accepted,
    output logic signed [mlsf_pkg::DE_W-1:0]         m_energy_change
);

    mlsf_pkg::cmd_t cmd;

    // Controller: sequences each item and owns both handshakes.
    mlsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd)
    );

    // Datapath: lattice memory, threshold table, sums and result registers.
    mlsf_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_action          (s_action),
        .s_column          (s_column),
        .s_row             (s_row),
        .s_spin_in         (s_spin_in),
        .s_draw            (s_draw),
        .s_level           (s_level),
        .s_threshold_value (s_threshold_value),
        .cmd               (cmd),
        .m_spin_out        (m_spin_out),
        .m_accepted        (m_accepted),
        .m_energy_change   (m_energy_change)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlsf_pkg::*;

    // The package names modes 0..2; code 3 falls back to the eight-cell scan.
    localparam logic [MODE_W-1:0] MODE_EIGHT_ALIAS = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic                spin_in;
        logic [DRAW_W-1:0]   draw;
        logic [LEVEL_W-1:0]  level;
        logic [THR_W-1:0]    threshold_value;
    } spin_item_t;

    typedef struct packed {
        logic                   spin_out;
        logic                   accepted;
        logic signed [DE_W-1:0] energy_change;
    } spin_result_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } coord_t;

    // Clock, reset and block ports; every input starts at a known value.
    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [MODE_W-1:0]        cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ACTION_W-1:0]      s_action = '0;
    logic [COORD_W-1:0]       s_column = '0;
    logic [COORD_W-1:0]       s_row = '0;
    logic                     s_spin_in = 1'b0;
    logic [DRAW_W-1:0]        s_draw = '0;
    logic [LEVEL_W-1:0]       s_level = '0;
    logic [THR_W-1:0]         s_threshold_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_spin_out;
    logic                     m_accepted;
    logic signed [DE_W-1:0]   m_energy_change;

    // Predicted state of the block.
    bit                lattice_model [SIDE][SIDE];
    logic [THR_W-1:0]  threshold_model [SLOTS];
    logic [MODE_W-1:0] model_mode = MODE_EIGHT;

    // Stimulus bookkeeping: which cells hold a known spin.
    bit         cell_written [SIDE][SIDE];
    coord_t     written_cells [$];
    spin_item_t pending_items [$];
    spin_result_t expected_results [$];
    int         queued_items;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         fail_count = 0;
    bit         s_took = 1'b0;

    metropolis_lattice_spin_flip_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_column          (s_column),
        .s_row             (s_row),
        .s_spin_in         (s_spin_in),
        .s_draw            (s_draw),
        .s_level           (s_level),
        .s_threshold_value (s_threshold_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_spin_out        (m_spin_out),
        .m_accepted        (m_accepted),
        .m_energy_change   (m_energy_change)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one item to the predicted lattice and table and returns its result.
    function automatic spin_result_t apply_spin_item(spin_item_t it);
        spin_result_t res;
        int s;
        int near_sum;
        int far_sum;
        int ar;
        int ac;
        int reach;
        int de;
        int slot;
        bit use_cell;
        logic [COORD_W-1:0] nr;
        logic [COORD_W-1:0] nc;
        res = '0;
        case (it.action)
            ACT_LOAD: begin
                lattice_model[it.row][it.column] = it.spin_in;
                res.spin_out = it.spin_in;
            end
            ACT_READ: begin
                res.spin_out = lattice_model[it.row][it.column];
            end
            ACT_THRESH: begin
                threshold_model[it.level] = it.threshold_value;
            end
            default: begin
                s = lattice_model[it.row][it.column] ? 1 : -1;
                near_sum = 0;
                far_sum = 0;
                for (int dr = -2; dr <= 2; dr++) begin
                    for (int dc = -2; dc <= 2; dc++) begin
                        ar = (dr < 0) ? -dr : dr;
                        ac = (dc < 0) ? -dc : dc;
                        reach = (ar > ac) ? ar : ac;
                        if (model_mode == MODE_ORTHO) begin
                            use_cell = (ar + ac == 1);
                        end else if (model_mode == MODE_RING2) begin
                            use_cell = (reach != 0);
                        end else begin
                            use_cell = (reach == 1);
                        end
                        if (use_cell) begin
                            // Coordinates wrap on the torus by plain truncation.
                            nr = it.row + COORD_W'(dr);
                            nc = it.column + COORD_W'(dc);
                            if (reach == 1) begin
                                near_sum += lattice_model[nr][nc] ? 1 : -1;
                            end else begin
                                far_sum += lattice_model[nr][nc] ? 1 : -1;
                            end
                        end
                    end
                end
                de = 2 * s * near_sum - s * far_sum;
                res.accepted = 1'b1;
                if (de > 0) begin
                    slot = de / 2 - 1;
                    if (it.draw >= threshold_model[slot]) begin
                        res.accepted = 1'b0;
                    end
                end
                if (res.accepted) begin
                    lattice_model[it.row][it.column] = !lattice_model[it.row][it.column];
                end
                res.spin_out = lattice_model[it.row][it.column];
                res.energy_change = DE_W'(de);
            end
        endcase
        return res;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Draws lean toward zero, the top of the legal range and the all-ones code.
    function automatic logic [DRAW_W-1:0] rand_draw();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DRAW_W'(999);
            2: return '1;
            default: return DRAW_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [THR_W-1:0] rand_threshold();
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2, 3: return THR_W'(1000);
            4: return '1;
            default: return THR_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic coord_t random_coord();
        coord_t at;
        at.row = COORD_W'($urandom);
        at.col = COORD_W'($urandom);
        return at;
    endfunction

    function automatic coord_t offset_coord(coord_t at, int dr, int dc);
        coord_t nb;
        nb.row = at.row + COORD_W'(dr);
        nb.col = at.col + COORD_W'(dc);
        return nb;
    endfunction

    // Fields that an action ignores still carry random bits.
    function automatic spin_item_t random_fields();
        spin_item_t it;
        it.action = ACTION_W'($urandom_range(0, 3));
        it.column = COORD_W'($urandom);
        it.row = COORD_W'($urandom);
        it.spin_in = 1'($urandom);
        it.draw = rand_draw();
        it.level = LEVEL_W'($urandom);
        it.threshold_value = rand_threshold();
        return it;
    endfunction

    function automatic void push_item(spin_item_t it);
        coord_t at;
        pending_items.push_back(it);
        queued_items++;
        if (it.action == ACT_LOAD && !cell_written[it.row][it.column]) begin
            cell_written[it.row][it.column] = 1'b1;
            at.row = it.row;
            at.col = it.column;
            written_cells.push_back(at);
        end
    endfunction

    function automatic void queue_load(coord_t at, logic spin);
        spin_item_t it;
        it = random_fields();
        it.action = ACT_LOAD;
        it.row = at.row;
        it.column = at.col;
        it.spin_in = spin;
        push_item(it);
    endfunction

    function automatic void queue_read(coord_t at);
        spin_item_t it;
        it = random_fields();
        it.action = ACT_READ;
        it.row = at.row;
        it.column = at.col;
        push_item(it);
    endfunction

    function automatic void queue_step(coord_t at);
        spin_item_t it;
        it = random_fields();
        it.action = ACT_STEP;
        it.row = at.row;
        it.column = at.col;
        push_item(it);
    endfunction

    function automatic void queue_threshold(logic [LEVEL_W-1:0] level, logic [THR_W-1:0] value);
        spin_item_t it;
        it = random_fields();
        it.action = ACT_THRESH;
        it.level = level;
        it.threshold_value = value;
        push_item(it);
    endfunction

    // Steps around a cell, first loading any cell of its 5x5 patch still unknown.
    function automatic void step_sequence();
        coord_t center;
        coord_t nb;
        if (written_cells.size() != 0 && roll(92)) begin
            center = written_cells[$urandom_range(0, written_cells.size() - 1)];
        end else begin
            center = random_coord();
        end
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                nb = offset_coord(center, dr, dc);
                if (!cell_written[nb.row][nb.col]) begin
                    queue_load(nb, 1'($urandom));
                end
            end
        end
        repeat ($urandom_range(1, 3)) queue_step(center);
    endfunction

    // Loads a ring-shaped patch so that the largest energy changes come up.
    function automatic void pattern_sequence();
        coord_t center;
        logic c;
        logic a;
        logic b;
        logic v;
        bit noisy;
        int reach;
        center = random_coord();
        c = 1'($urandom);
        a = roll(50) ? c : !c;
        b = roll(70) ? !a : a;
        noisy = roll(50);
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                reach = ((dr < 0 ? -dr : dr) > (dc < 0 ? -dc : dc)) ?
                        (dr < 0 ? -dr : dr) : (dc < 0 ? -dc : dc);
                v = (reach == 0) ? c : (reach == 1) ? a : b;
                if (noisy && roll(5)) begin
                    v = !v;
                end
                queue_load(offset_coord(center, dr, dc), v);
            end
        end
        repeat ($urandom_range(1, 3)) queue_step(center);
    endfunction

    function automatic void random_items(int budget);
        int pick;
        while (queued_items < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                step_sequence();
            end else if (pick < 50) begin
                pattern_sequence();
            end else if (pick < 68) begin
                queue_load(random_coord(), 1'($urandom));
            end else if (pick < 86 && written_cells.size() != 0) begin
                queue_read(written_cells[$urandom_range(0, written_cells.size() - 1)]);
            end else begin
                queue_threshold(LEVEL_W'($urandom), rand_threshold());
            end
        end
    endfunction

    // Fills the whole threshold table, then touches the origin and the far corner.
    function automatic void directed_items();
        spin_item_t it;
        coord_t corner;
        coord_t origin;
        for (int k = 0; k < SLOTS; k++) begin
            queue_threshold(LEVEL_W'(k), (k == 0) ? THR_W'(1000) : (k == 1) ? '0 :
                            (k == SLOTS - 1) ? '1 : THR_W'($urandom_range(1, 999)));
        end
        corner.row = '1;
        corner.col = '1;
        origin = '0;
        // All-zero item: a down spin loaded at the origin.
        it = '0;
        it.action = ACT_LOAD;
        push_item(it);
        // Every other field at its top value, as a load of the far corner.
        it = '1;
        it.action = ACT_LOAD;
        push_item(it);
        queue_read(corner);
        queue_read(origin);
        queue_load(origin, 1'b1);
        queue_read(origin);
    endfunction

    // Waits until no item is held or pending and every result has arrived.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);
    endtask

    task automatic run_phase(logic [MODE_W-1:0] mode, int send_pct, int recv_pct,
                             int budget, bit with_directed, bit hold_midway);
        wait_drained();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        model_mode = mode;
        queued_items = 0;
        if (with_directed) begin
            directed_items();
        end
        if (hold_midway) begin
            // The sender stops until everything sent so far has come back.
            random_items(budget / 2);
            wait_drained();
        end
        random_items(budget);
    endtask

    // Sender side: inputs change on the falling edge.
    always @(negedge aclk) begin
        spin_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (pending_items.size() != 0 && !roll(send_idle_pct)) begin
                nxt = pending_items.pop_front();
                s_valid <= 1'b1;
                s_action <= nxt.action;
                s_column <= nxt.column;
                s_row <= nxt.row;
                s_spin_in <= nxt.spin_in;
                s_draw <= nxt.draw;
                s_level <= nxt.level;
                s_threshold_value <= nxt.threshold_value;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= !roll(recv_stall_pct);
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge aclk) begin
        spin_item_t seen;
        spin_result_t want;
        s_took = aresetn && s_valid && s_ready;
        if (s_took) begin
            seen.action = s_action;
            seen.column = s_column;
            seen.row = s_row;
            seen.spin_in = s_spin_in;
            seen.draw = s_draw;
            seen.level = s_level;
            seen.threshold_value = s_threshold_value;
            expected_results.push_back(apply_spin_item(seen));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: spin_out %0b accepted %0b energy_change %0d",
                       m_spin_out, m_accepted, m_energy_change);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_spin_out !== want.spin_out) begin
                    $error("spin_out: expected %0b, got %0b", want.spin_out, m_spin_out);
                    fail_count++;
                end
                if (m_accepted !== want.accepted) begin
                    $error("accepted: expected %0b, got %0b", want.accepted, m_accepted);
                    fail_count++;
                end
                if (m_energy_change !== want.energy_change) begin
                    $error("energy_change: expected %0d, got %0d",
                           want.energy_change, m_energy_change);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus phases: neighborhood mode and idling change only while drained.
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_phase(MODE_EIGHT, 0, 0, 240, 1'b1, 1'b0);
        run_phase(MODE_ORTHO, 61, 0, 240, 1'b0, 1'b0);
        run_phase(MODE_RING2, 0, 61, 240, 1'b0, 1'b0);
        run_phase(MODE_EIGHT_ALIAS, 11, 11, 240, 1'b0, 1'b0);
        run_phase(MODE_RING2, 0, 0, 240, 1'b0, 1'b1);
        run_phase(MODE_ORTHO, 11, 11, 240, 1'b0, 1'b0);
        run_phase(MODE_EIGHT, 61, 0, 230, 1'b0, 1'b0);
        run_phase(MODE_RING2, 0, 61, 230, 1'b0, 1'b0);
        wait_drained();
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("metropolis_lattice_spin_flip_top: match");
        end else begin
            $display("metropolis_lattice_spin_flip_top: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("metropolis_lattice_spin_flip_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
